// ----- src/tbu_pkg.sv -----
// Shared constants, types and sequencer codes for the tangent/bitangent unit.
package tbu_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int UNIT_FRAC_BITS = 14;
    localparam int NORM_BITS      = 30;
    localparam int DW             = COORD_WIDTH + 1;
    localparam int PW             = 2 * DW;
    localparam int WW             = PW + 1;
    localparam int OUT_W          = UNIT_FRAC_BITS + 2;
    localparam int QW             = UNIT_FRAC_BITS + 1;
    localparam int SUM_W          = 2 * NORM_BITS + 2;
    localparam int LEN_W          = NORM_BITS + 1;
    localparam int NUM_W          = NORM_BITS + UNIT_FRAC_BITS + 1;
    localparam int REM_W          = LEN_W + 1;
    localparam int SQRT_STEPS     = SUM_W / 2;
    localparam int MUL_STEPS      = 14;
    localparam int LZ_JUMP        = 8;
    localparam int CNT_W          = 6;

    typedef struct packed {
        logic [2:0][DW-1:0] e1;
        logic [2:0][DW-1:0] e2;
        logic [DW-1:0]      du1;
        logic [DW-1:0]      dv1;
        logic [DW-1:0]      du2;
        logic [DW-1:0]      dv2;
    } delta_t;

    typedef struct packed {
        logic [5:0][OUT_W-1:0] vec;
        logic                  degen;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL  = 9'b000000010,
        ST_LOAD = 9'b000000100,
        ST_LZ   = 9'b000001000,
        ST_SQ   = 9'b000010000,
        ST_SQRT = 9'b000100000,
        ST_DIVI = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

endpackage

// ----- src/triangle_tangent_bitangent_unit.sv -----
// Top level: vertex capture, delta forming, output word register.
// Vertices arrive one word at a time; the first two of a triangle are held in
// registers. The third starts the shared-multiplier sequencer: cross products,
// then per vector a load step, a leading-zero scan, the squares, the isqrt and
// a divide per component, run by the bit-serial square root and divider.
// A zero determinant or a zero vector ends the run early as degenerate.
// The input is not ready during that run.
// The result word waits in an output register while new vertices are taken.
module triangle_tangent_bitangent_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // tangent_x/y/z, bitangent_x/y/z
    output logic         m_axis_tuser   // degenerate
);

    localparam int CW = tbu_pkg::COORD_WIDTH;

    logic [1:0] slot_reg, slot_next;
    logic [CW-1:0] v0_reg [5], v0_next [5];
    logic [CW-1:0] v1_reg [5], v1_next [5];
    logic [CW-1:0] fin [5];
    logic m_valid_reg, m_valid_next;
    logic [95:0] m_data_reg, m_data_next;
    logic m_user_reg, m_user_next;
    logic accept, start, take;
    tbu_pkg::delta_t delta;
    tbu_pkg::core_stat_t stat;
    tbu_pkg::result_t result;

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            fin[i] = s_axis_tdata[i*CW +: CW];
        end
    end

    function automatic logic [tbu_pkg::DW-1:0] sub_ext(input logic [CW-1:0] a,
                                                        input logic [CW-1:0] b);
        sub_ext = {a[CW-1], a} - {b[CW-1], b};
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            delta.e1[i] = sub_ext(v1_reg[i], v0_reg[i]);
            delta.e2[i] = sub_ext(fin[i], v0_reg[i]);
        end
        delta.du1 = sub_ext(v1_reg[3], v0_reg[3]);
        delta.dv1 = sub_ext(v1_reg[4], v0_reg[4]);
        delta.du2 = sub_ext(fin[3], v0_reg[3]);
        delta.dv2 = sub_ext(fin[4], v0_reg[4]);
    end

    assign s_axis_tready = stat.idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && (slot_reg == 2'd2);
    assign take          = !m_valid_reg || m_axis_tready;

    tbu_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .delta  (delta),
        .take   (take),
        .stat   (stat),
        .result (result)
    );

    always_comb
    begin
        slot_next = slot_reg;
        v0_next   = v0_reg;
        v1_next   = v1_reg;
        if (accept)
        begin
            unique case (slot_reg)
                2'd1:
                begin
                    v1_next   = fin;
                    slot_next = 2'd2;
                end
                2'd2:    slot_next = 2'd0;
                default:
                begin
                    v0_next   = fin;
                    slot_next = 2'd1;
                end
            endcase
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (stat.done && take)
        begin
            m_valid_next = 1'b1;
            m_data_next  = result.vec;
            m_user_next  = result.degen;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v0_reg     <= v0_next;
        v1_reg     <= v1_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate word carries nonzero vectors");

    a_busy_after_third: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("input ready right after third vertex");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg != 2'd3)
        else $error("vertex slot out of range");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped");
`endif

endmodule

// ----- src/tbu_mul.sv -----
// Shared signed multiplier.
module tbu_mul
(
    input  logic signed [tbu_pkg::DW-1:0] a,
    input  logic signed [tbu_pkg::DW-1:0] b,
    output logic signed [tbu_pkg::PW-1:0] p
);

    assign p = a * b;

endmodule

// ----- src/tbu_core.sv -----
// Sequencer and datapath: cross products, normalize, isqrt and divide.
module tbu_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tbu_pkg::delta_t      delta,
    input  logic                 take,
    output tbu_pkg::core_stat_t  stat,
    output tbu_pkg::result_t     result
);

    tbu_pkg::state_t state_reg, state_next;
    logic [tbu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic vec_reg, vec_next;
    logic [1:0] comp_reg, comp_next;
    logic signed [tbu_pkg::WW-1:0] acc_reg, acc_next;
    logic det_neg_reg, det_neg_next, det_zero_reg, det_zero_next;
    logic signed [tbu_pkg::WW-1:0] t_reg [3], t_next [3];
    logic signed [tbu_pkg::WW-1:0] b_reg [3], b_next [3];
    logic [tbu_pkg::WW-1:0] mag_reg [3], mag_next [3];
    logic [2:0] neg_reg, neg_next;
    logic [tbu_pkg::SUM_W-1:0] n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic [tbu_pkg::LEN_W-1:0] len_reg, len_next;
    logic [tbu_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [tbu_pkg::QW-1:0] nlo_reg, nlo_next, q_reg, q_next;
    logic [5:0][tbu_pkg::OUT_W-1:0] out_reg, out_next;
    logic degen_reg, degen_next;
    tbu_pkg::delta_t d_reg, d_next;

    logic signed [tbu_pkg::DW-1:0] op_a, op_b;
    logic signed [tbu_pkg::PW-1:0] prod;
    logic signed [tbu_pkg::WW-1:0] pe, diff;
    logic [tbu_pkg::WW-1:0] orv;
    logic signed [tbu_pkg::WW-1:0] src [3];
    logic [tbu_pkg::NORM_BITS-1:0] vsel;
    logic [tbu_pkg::NUM_W-1:0] numer;
    logic [tbu_pkg::SUM_W-1:0] trial;
    logic [tbu_pkg::REM_W-1:0] tr;
    logic ge;
    logic [tbu_pkg::OUT_W-1:0] qs, ov;
    logic [2:0] pair;

    tbu_mul u_mul (.a(op_a), .b(op_b), .p(prod));

    assign pair = cnt_reg[3:1];
    assign pe   = {{(tbu_pkg::WW-tbu_pkg::PW){prod[tbu_pkg::PW-1]}}, prod};
    assign diff = acc_reg - pe;
    assign orv  = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign vsel = mag_reg[comp_reg][tbu_pkg::WW-1 -: tbu_pkg::NORM_BITS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            src[i] = vec_reg ? b_reg[i] : t_reg[i];
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == tbu_pkg::ST_SQ)
        begin
            op_a = $signed({{(tbu_pkg::DW-tbu_pkg::NORM_BITS){1'b0}},
                mag_reg[cnt_reg[1:0]][tbu_pkg::WW-1 -: tbu_pkg::NORM_BITS]});
            op_b = op_a;
        end
        else
        begin
            unique case (pair)
                3'd0:
                begin
                    op_a = $signed(cnt_reg[0] ? d_reg.du2 : d_reg.du1);
                    op_b = $signed(cnt_reg[0] ? d_reg.dv1 : d_reg.dv2);
                end
                3'd1, 3'd2, 3'd3:
                begin
                    op_a = $signed(cnt_reg[0] ? d_reg.dv1 : d_reg.dv2);
                    op_b = $signed(cnt_reg[0] ? d_reg.e2[2'(pair - 3'd1)]
                                              : d_reg.e1[2'(pair - 3'd1)]);
                end
                3'd4, 3'd5, 3'd6:
                begin
                    op_a = $signed(cnt_reg[0] ? d_reg.du2 : d_reg.du1);
                    op_b = $signed(cnt_reg[0] ? d_reg.e1[2'(pair - 3'd4)]
                                              : d_reg.e2[2'(pair - 3'd4)]);
                end
                default:
                begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    assign numer = {1'b0, vsel, {tbu_pkg::UNIT_FRAC_BITS{1'b0}}}
                 + {{(tbu_pkg::NUM_W-tbu_pkg::LEN_W){1'b0}}, len_reg >> 1};
    assign trial = res_reg + bit_reg;
    assign tr    = {rem_reg[tbu_pkg::REM_W-2:0], nlo_reg[tbu_pkg::QW-1]};
    assign ge    = tr >= {1'b0, len_reg};
    assign qs    = {1'b0, q_reg[tbu_pkg::QW-2:0], ge};
    assign ov    = neg_reg[comp_reg] ? (~qs + 1'b1) : qs;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        vec_next     = vec_reg;
        comp_next    = comp_reg;
        acc_next     = acc_reg;
        det_neg_next = det_neg_reg;
        det_zero_next = det_zero_reg;
        t_next       = t_reg;
        b_next       = b_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        n_next       = n_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        nlo_next     = nlo_reg;
        q_next       = q_reg;
        out_next     = out_reg;
        degen_next   = degen_reg;
        d_next       = d_reg;
        unique case (state_reg)
            tbu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    d_next     = delta;
                    degen_next = 1'b0;
                    out_next   = '0;
                    cnt_next   = '0;
                    state_next = tbu_pkg::ST_MUL;
                end
            end
            tbu_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (!cnt_reg[0])
                begin
                    acc_next = pe;
                end
                else
                begin
                    unique case (pair)
                        3'd0:
                        begin
                            det_neg_next  = diff[tbu_pkg::WW-1];
                            det_zero_next = (diff == '0);
                        end
                        3'd1, 3'd2, 3'd3: t_next[2'(pair - 3'd1)] = diff;
                        3'd4, 3'd5, 3'd6: b_next[2'(pair - 3'd4)] = diff;
                        default: ;
                    endcase
                end
                if (cnt_reg == tbu_pkg::CNT_W'(tbu_pkg::MUL_STEPS - 1))
                begin
                    vec_next = 1'b0;
                    if (det_zero_reg)
                    begin
                        degen_next = 1'b1;
                        state_next = tbu_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = tbu_pkg::ST_LOAD;
                    end
                end
            end
            tbu_pkg::ST_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_next[i] = src[i][tbu_pkg::WW-1] ? (~src[i] + 1'b1) : src[i];
                    neg_next[i] = src[i][tbu_pkg::WW-1] ^ det_neg_reg;
                end
                if (src[0] == '0 && src[1] == '0 && src[2] == '0)
                begin
                    degen_next = 1'b1;
                    out_next   = '0;
                    state_next = tbu_pkg::ST_FIN;
                end
                else
                begin
                    state_next = tbu_pkg::ST_LZ;
                end
            end
            tbu_pkg::ST_LZ:
            begin
                if (orv[tbu_pkg::WW-1])
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = tbu_pkg::ST_SQ;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (orv[tbu_pkg::WW-1 -: tbu_pkg::LZ_JUMP] == '0)
                            mag_next[i] = mag_reg[i] << tbu_pkg::LZ_JUMP;
                        else
                            mag_next[i] = mag_reg[i] << 1;
                    end
                end
            end
            tbu_pkg::ST_SQ:
            begin
                acc_next = acc_reg + pe;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tbu_pkg::CNT_W'(2))
                begin
                    n_next     = acc_reg[tbu_pkg::SUM_W-1:0] + prod[tbu_pkg::SUM_W-1:0];
                    res_next   = '0;
                    bit_next   = tbu_pkg::SUM_W'(1) << (tbu_pkg::SUM_W - 2);
                    cnt_next   = '0;
                    state_next = tbu_pkg::ST_SQRT;
                end
            end
            tbu_pkg::ST_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_next   = n_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tbu_pkg::CNT_W'(tbu_pkg::SQRT_STEPS - 1))
                begin
                    len_next   = res_next[tbu_pkg::LEN_W-1:0];
                    comp_next  = 2'd0;
                    state_next = tbu_pkg::ST_DIVI;
                end
            end
            tbu_pkg::ST_DIVI:
            begin
                rem_next   = {{(tbu_pkg::REM_W-(tbu_pkg::NUM_W-tbu_pkg::QW)){1'b0}},
                              numer[tbu_pkg::NUM_W-1:tbu_pkg::QW]};
                nlo_next   = numer[tbu_pkg::QW-1:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = tbu_pkg::ST_DIV;
            end
            tbu_pkg::ST_DIV:
            begin
                rem_next = ge ? (tr - {1'b0, len_reg}) : tr;
                q_next   = {q_reg[tbu_pkg::QW-2:0], ge};
                nlo_next = nlo_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tbu_pkg::CNT_W'(tbu_pkg::QW - 1))
                begin
                    out_next[{1'b0, vec_reg, 1'b0} + {1'b0, vec_reg} + {1'b0, comp_reg}] = ov;
                    if (comp_reg == 2'd2)
                    begin
                        if (!vec_reg)
                        begin
                            vec_next   = 1'b1;
                            state_next = tbu_pkg::ST_LOAD;
                        end
                        else
                        begin
                            state_next = tbu_pkg::ST_FIN;
                        end
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = tbu_pkg::ST_DIVI;
                    end
                end
            end
            tbu_pkg::ST_FIN:
            begin
                if (take)
                    state_next = tbu_pkg::ST_IDLE;
            end
            default: state_next = tbu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbu_pkg::ST_IDLE;
            cnt_reg   <= '0;
            vec_reg   <= 1'b0;
            comp_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vec_reg   <= vec_next;
            comp_reg  <= comp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        det_neg_reg  <= det_neg_next;
        det_zero_reg <= det_zero_next;
        t_reg        <= t_next;
        b_reg        <= b_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        n_reg        <= n_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        nlo_reg      <= nlo_next;
        q_reg        <= q_next;
        out_reg      <= out_next;
        degen_reg    <= degen_next;
        d_reg        <= d_next;
    end

    assign stat.idle    = (state_reg == tbu_pkg::ST_IDLE);
    assign stat.done    = (state_reg == tbu_pkg::ST_FIN);
    assign result.vec   = degen_reg ? '0 : out_reg;
    assign result.degen = degen_reg;

endmodule

// ----- sim/triangle_tangent_bitangent_unit_checker.sv -----
// Checker for the tangent/bitangent unit: watches both streams and checks every result word.
module triangle_tangent_bitangent_unit_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [tbu_pkg::OUT_W-1:0] vec [6];
        logic                      degen;
    } frame_t;

    frame_t      frames_due [$];
    logic [1:0]  corner;
    wide_t       corner_pos [2][3];
    wide_t       corner_uv  [2][2];

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // scale to a 30-bit max magnitude, then divide by the length with rounding
    function automatic logic unit_vector(input wide_t c [3],
                                         output logic [tbu_pkg::OUT_W-1:0] o [3]);
        wide_t           m [3];
        logic            neg [3];
        int              lmax, bl;
        longint unsigned v [3], sum, len, q;
        lmax = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            m[i]   = neg[i] ? -c[i] : c[i];
            bl = 0;
            for (int k = 127; k >= 0; k--)
                if (m[i][k] && bl == 0) bl = k + 1;
            if (bl > lmax) lmax = bl;
        end
        if (lmax == 0) return 1'b0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (lmax > tbu_pkg::NORM_BITS)
                v[i] = 64'(m[i] >> (lmax - tbu_pkg::NORM_BITS));
            else
                v[i] = 64'(m[i] << (tbu_pkg::NORM_BITS - lmax));
            sum += v[i] * v[i];
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q    = ((v[i] << tbu_pkg::UNIT_FRAC_BITS) + (len >> 1)) / len;
            o[i] = neg[i] ? tbu_pkg::OUT_W'(-q) : tbu_pkg::OUT_W'(q);
        end
        return 1'b1;
    endfunction

    function automatic frame_t triangle_frame(input logic [159:0] w);
        wide_t                     p [3], e1 [3], e2 [3], t [3], b [3];
        wide_t                     u, v, du1, dv1, du2, dv2, det;
        logic [tbu_pkg::OUT_W-1:0] ot [3], ob [3];
        logic                      ok;
        frame_t                    f;
        for (int i = 0; i < 3; i++) p[i] = $signed(w[32*i +: 32]);
        u = $signed(w[127:96]);
        v = $signed(w[159:128]);
        for (int i = 0; i < 3; i++) begin
            e1[i] = corner_pos[1][i] - corner_pos[0][i];
            e2[i] = p[i] - corner_pos[0][i];
        end
        du1 = corner_uv[1][0] - corner_uv[0][0];
        dv1 = corner_uv[1][1] - corner_uv[0][1];
        du2 = u - corner_uv[0][0];
        dv2 = v - corner_uv[0][1];
        det = du1 * dv2 - du2 * dv1;
        for (int i = 0; i < 3; i++) begin
            t[i] = dv2 * e1[i] - dv1 * e2[i];
            b[i] = du1 * e2[i] - du2 * e1[i];
            if (det < 0) begin
                t[i] = -t[i];
                b[i] = -b[i];
            end
        end
        ok = det != 0;
        if (ok) ok = unit_vector(t, ot);
        if (ok) ok = unit_vector(b, ob);
        for (int i = 0; i < 3; i++) begin
            f.vec[i]     = ok ? ot[i] : '0;
            f.vec[3 + i] = ok ? ob[i] : '0;
        end
        f.degen = !ok;
        return f;
    endfunction

    task automatic report(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        errors++;
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        frame_t f;
        if (!rst_n)
            corner <= 2'd0;
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (corner == 2'd2) begin
                    frames_due.push_back(triangle_frame(s_axis_tdata));
                    corner <= 2'd0;
                end else begin
                    for (int i = 0; i < 3; i++)
                        corner_pos[corner[0]][i] = $signed(s_axis_tdata[32*i +: 32]);
                    corner_uv[corner[0]][0] = $signed(s_axis_tdata[127:96]);
                    corner_uv[corner[0]][1] = $signed(s_axis_tdata[159:128]);
                    corner <= corner + 2'd1;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (frames_due.size() == 0)
                    report("result word with none expected");
                else begin
                    f = frames_due.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (m_axis_tdata[16*i +: 16] !== f.vec[i])
                            report($sformatf("component %0d got %h want %h",
                                   i, m_axis_tdata[16*i +: 16], f.vec[i]));
                    if (m_axis_tuser !== f.degen)
                        report($sformatf("degenerate got %b want %b", m_axis_tuser, f.degen));
                end
            end
            pending = frames_due.size();
        end
    end
endmodule

// ----- sim/triangle_tangent_bitangent_unit_tb.sv -----
// Testbench top for the tangent/bitangent unit: stimulus, stall control and verdict.
module triangle_tangent_bitangent_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    int           errors;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cycles;
    int           cycle_count;

    triangle_tangent_bitangent_unit dut (.*);

    triangle_tangent_bitangent_unit_checker chk (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 800000) begin
            $display("triangle_tangent_bitangent_unit_tb failed");
            $finish;
        end
    end

    // receiver; a nonzero hold_cycles forces a long hold-off
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else
            m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    task automatic send_word(input logic [31:0] px, py, pz, tu, tv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {tv, tu, pz, py, px};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] coord(input int kind);
        case (kind)
            0:       return $urandom();
            1:       return $urandom_range(8192) - 4096;
            2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return ($urandom_range(400) - 200) << 16;
        endcase
    endfunction

    // kind picks value ranges; flat gives equal UVs, pinched gives equal positions
    task automatic send_triangle(input int kind, input bit flat, input bit pinched);
        logic [31:0] p [3], uv [2];
        p  = '{coord(kind), coord(kind), coord(kind)};
        uv = '{coord(kind), coord(kind)};
        for (int k = 0; k < 3; k++) begin
            if (!pinched) p = '{coord(kind), coord(kind), coord(kind)};
            if (!flat)    uv = '{coord(kind), coord(kind)};
            send_word(p[0], p[1], p[2], uv[0], uv[1]);
        end
    endtask

    task automatic random_triangles(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            send_triangle($urandom_range(3), r < 8, r >= 8 && r < 16);
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        cycle_count    = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, unit right triangle, flat UVs, coincident positions
        send_word(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0);
        send_word(32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000);
        send_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_word(32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h7fffffff);
        send_word(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000, 32'h7fffffff);
        send_word(32'h1, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_word(32'h80000000, 32'h1, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_triangle(1, 1'b1, 1'b0);
        send_triangle(3, 1'b0, 1'b1);
        send_triangle(2, 1'b0, 1'b0);
        send_triangle(0, 1'b0, 1'b0);

        random_triangles(60);
        send_idle_pct = 68;
        random_triangles(55);
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        random_triangles(55);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        random_triangles(40);

        // long hold-off while vertices keep coming, then drain fully
        hold_cycles = 1500;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_triangles(10);
        while (pending != 0) @(negedge clk);
        random_triangles(55);

        while (pending != 0) @(negedge clk);
        repeat (400) @(negedge clk);
        if (errors == 0)
            $display("triangle_tangent_bitangent_unit_tb passed");
        else
            $display("triangle_tangent_bitangent_unit_tb failed");
        $finish;
    end
endmodule
